// File: hdl/ebcpu_pkg.sv
`timescale 1ns / 1ps
// Shared widths and instruction codes for the 8-bit CPU step block.
package ebcpu_pkg;
    localparam int unsigned IN_W  = 40;
    localparam int unsigned OUT_W = 48;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // sources
    localparam logic [2:0] SRC_LIT = 3'd0;
    localparam logic [2:0] SRC_R   = 3'd1;
    localparam logic [2:0] SRC_M   = 3'd2;
    localparam logic [2:0] SRC_L   = 3'd3;
    localparam logic [2:0] SRC_H   = 3'd4;
    localparam logic [2:0] SRC_SI  = 3'd5;
    localparam logic [2:0] SRC_P   = 3'd6;
    localparam logic [2:0] SRC_ALU = 3'd7;

    // destinations
    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_R    = 4'd1;
    localparam logic [3:0] DST_M    = 4'd2;
    localparam logic [3:0] DST_L    = 4'd3;
    localparam logic [3:0] DST_H    = 4'd4;
    localparam logic [3:0] DST_SO   = 4'd5;
    localparam logic [3:0] DST_P    = 4'd6;
    localparam logic [3:0] DST_F    = 4'd7;
    localparam logic [3:0] DST_D    = 4'd8;
    localparam logic [3:0] DST_G    = 4'd9;
    localparam logic [3:0] DST_J    = 4'd10;
    localparam logic [3:0] DST_T    = 4'd11;
    localparam logic [3:0] DST_E    = 4'd12;
    localparam logic [3:0] DST_C    = 4'd13;
    localparam logic [3:0] DST_A    = 4'd14;
    localparam logic [3:0] DST_B    = 4'd15;

    // signals (destination none)
    localparam logic [2:0] SIG_SCI = 3'd1;
    localparam logic [2:0] SIG_SCO = 3'd2;
    localparam logic [2:0] SIG_CLL = 3'd3;
    localparam logic [2:0] SIG_CLH = 3'd4;
    localparam logic [2:0] SIG_TRI = 3'd5;
    localparam logic [2:0] SIG_SPI = 3'd6;
    localparam logic [2:0] SIG_SPD = 3'd7;

    // ALU operations (low nibble of F)
    localparam logic [3:0] ALU_A     = 4'd0;
    localparam logic [3:0] ALU_B     = 4'd1;
    localparam logic [3:0] ALU_NOTA  = 4'd2;
    localparam logic [3:0] ALU_NOTB  = 4'd3;
    localparam logic [3:0] ALU_SHLA  = 4'd4;
    localparam logic [3:0] ALU_SHLB  = 4'd5;
    localparam logic [3:0] ALU_SHRA  = 4'd6;
    localparam logic [3:0] ALU_SHRB  = 4'd7;
    localparam logic [3:0] ALU_AND   = 4'd8;
    localparam logic [3:0] ALU_OR    = 4'd9;
    localparam logic [3:0] ALU_XOR   = 4'd10;
    localparam logic [3:0] ALU_ADD   = 4'd11;
    localparam logic [3:0] ALU_CARRY = 4'd12;
    localparam logic [3:0] ALU_LT    = 4'd13;
    localparam logic [3:0] ALU_EQ    = 4'd14;
    localparam logic [3:0] ALU_GT    = 4'd15;

    localparam logic [7:0] GLOBAL_BASE = 8'd128;
    localparam logic [7:0] STACK_BASE  = 8'd192;
endpackage

// File: hdl/ebcpu_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ebcpu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// File: hdl/eight_bit_cpu_instruction_step.sv
`timescale 1ns / 1ps
// Top level of the 8-bit CPU step block: sequencer, registers and byte memory.
//
//  channel   dir   payload                          request taken when
//  s_axis    in    command,address,wdata,sin,pin    s_axis_tvalid & s_axis_tready
//  m_axis    out   result word (see port comment)   m_axis_tvalid & m_axis_tready
//
// Writes and no-ops go from the start state to done, reads pass through
// execute, and instructions pass through decode and, if needed, execute:
// fetch, an optional literal or memory read, and the execute/write-back all
// go through the single memory port in turn. Reset clears the CPU registers;
// memory contents are kept. A result held in the output register does not
// block the next request, but the following result waits for it to be taken.
module eight_bit_cpu_instruction_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], address[17:2], write_data[25:18], serial_in_bit[26],
    // parallel_in_data[34:27], zero pad
    input  logic [ebcpu_pkg::IN_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], program_counter[23:8], zero_flag[24], serial_clock[25],
    // serial_out_bit[26], serial_out_valid[27], bus_tristate[28],
    // parallel_out_valid[29], parallel_out_data[37:30], device_select[45:38], pad
    output logic [ebcpu_pkg::OUT_W-1:0] m_axis_tdata
);
    import ebcpu_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_EXEC   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]  r_state;
    logic [1:0]  r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_wdat, r_pin, r_ins;
    logic        r_sin;

    logic [7:0] r_pcl, r_pch, r_spl, r_sph, r_pg_r, r_dsel, r_pg_g, r_sp;
    logic [7:0] r_acc_a, r_acc_b, r_func, r_latch, r_sis, r_sos;
    logic       r_lwb, r_hold, r_zero, r_clk_line, r_tri;
    logic [7:0] r_rd, r_pod;
    logic       r_sob, r_sov, r_pov;
    logic       r_ovalid;
    logic [OUT_W-1:0] r_odata;

    logic        ram_we, ram_re;
    logic [15:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    logic [7:0]  w_acc, n_alu, alu_raw, n_src;
    logic [15:0] eff_addr;
    logic        n_zero;
    logic [8:0]  alu_sum;
    logic [3:0]  dst;
    logic [2:0]  src;

    ebcpu_ram #(.WIDTH(8), .DEPTH(65536)) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign dst = r_ins[3:0];
    assign src = r_ins[6:4];

    always_comb begin
        w_acc = r_lwb ? r_acc_b : r_acc_a;
        if (!w_acc[7]) begin
            eff_addr = {r_pg_r, w_acc};
        end else if (!w_acc[6]) begin
            eff_addr = {r_pg_g, w_acc};
        end else begin
            eff_addr = {r_sp, w_acc};
        end
    end

    // ALU: op in low nibble, high nibble added as offset
    always_comb begin
        alu_sum = {1'b0, r_acc_a} + {1'b0, r_acc_b};
        case (r_func[3:0])
            ALU_A:     alu_raw = r_acc_a;
            ALU_B:     alu_raw = r_acc_b;
            ALU_NOTA:  alu_raw = ~r_acc_a;
            ALU_NOTB:  alu_raw = ~r_acc_b;
            ALU_SHLA:  alu_raw = {r_acc_a[6:0], 1'b0};
            ALU_SHLB:  alu_raw = {r_acc_b[6:0], 1'b0};
            ALU_SHRA:  alu_raw = {1'b0, r_acc_a[7:1]};
            ALU_SHRB:  alu_raw = {1'b0, r_acc_b[7:1]};
            ALU_AND:   alu_raw = r_acc_a & r_acc_b;
            ALU_OR:    alu_raw = r_acc_a | r_acc_b;
            ALU_XOR:   alu_raw = r_acc_a ^ r_acc_b;
            ALU_ADD:   alu_raw = alu_sum[7:0];
            ALU_CARRY: alu_raw = {7'd0, alu_sum[8]};
            ALU_LT:    alu_raw = (r_acc_a < r_acc_b) ? 8'hFF : 8'h00;
            ALU_EQ:    alu_raw = (r_acc_a == r_acc_b) ? 8'hFF : 8'h00;
            default:   alu_raw = (r_acc_a > r_acc_b) ? 8'hFF : 8'h00;
        endcase
        n_alu  = r_hold ? r_latch : alu_raw + {r_func[7:4], 4'd0};
        n_zero = r_zero;
        case (src)
            SRC_LIT, SRC_M: n_src = ram_rdata;
            SRC_R:  n_src = r_pg_r;
            SRC_L:  n_src = r_spl;
            SRC_H:  n_src = r_sph;
            SRC_SI: n_src = r_sis;
            SRC_P:  n_src = r_pin;
            default: begin
                n_src  = n_alu;
                n_zero = r_hold ? r_zero : (n_alu == 8'd0);
            end
        endcase
    end

    // single memory port: who drives it depends on the step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = r_wdat;
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        case (r_state)
            ST_START: begin
                if (r_cmd == CMD_WRITE) begin
                    ram_we = 1'b1;
                end else if (r_cmd == CMD_READ) begin
                    ram_re = 1'b1;
                end else if (r_cmd == CMD_EXEC) begin
                    ram_re    = 1'b1;
                    ram_raddr = {r_pch, r_pcl};
                end
            end
            ST_DECODE: begin
                if (ram_rdata[7] && ram_rdata[6]) begin
                    ram_waddr = ram_rdata[4]
                        ? {r_sp, STACK_BASE | {5'd0, ram_rdata[2:0]}}
                        : {r_pg_g, GLOBAL_BASE | {5'd0, ram_rdata[2:0]}};
                    ram_raddr = ram_waddr;
                    ram_wdata = ram_rdata[5] ? r_acc_b : r_acc_a;
                    ram_we    = ram_rdata[3];
                    ram_re    = !ram_rdata[3];
                end else if (!ram_rdata[7] && ram_rdata[3:0] != DST_NONE) begin
                    if (ram_rdata[6:4] == SRC_LIT) begin
                        ram_re    = 1'b1;
                        ram_raddr = {r_pch, r_pcl};
                    end else if (ram_rdata[6:4] == SRC_M && ram_rdata[3:0] != DST_M) begin
                        ram_re    = 1'b1;
                        ram_raddr = eff_addr;
                    end
                end
            end
            ST_EXEC: begin
                if (r_cmd == CMD_EXEC && !r_ins[7] && dst == DST_M) begin
                    ram_we    = 1'b1;
                    ram_waddr = eff_addr;
                    ram_wdata = n_src;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_pcl <= '0; r_pch <= '0; r_spl <= '0; r_sph <= '0;
            r_pg_r <= '0; r_dsel <= '0; r_pg_g <= '0; r_sp <= '0;
            r_acc_a <= '0; r_acc_b <= '0; r_lwb <= 1'b0;
            r_func <= '0; r_latch <= '0; r_hold <= 1'b0; r_zero <= 1'b0;
            r_sis <= '0; r_sos <= '0; r_clk_line <= 1'b0; r_tri <= 1'b1;
        end else begin
            // in ST_DONE the output register is handled below
            if (m_axis_tready && r_state != ST_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd  <= s_axis_tdata[1:0];
                        r_addr <= s_axis_tdata[17:2];
                        r_wdat <= s_axis_tdata[25:18];
                        r_sin  <= s_axis_tdata[26];
                        r_pin  <= s_axis_tdata[34:27];
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_rd <= '0; r_pod <= '0;
                    r_sob <= 1'b0; r_sov <= 1'b0; r_pov <= 1'b0;
                    if (r_cmd == CMD_READ) begin
                        r_state <= ST_EXEC;
                    end else if (r_cmd == CMD_EXEC) begin
                        r_pcl   <= r_pcl + 8'd1;
                        r_state <= ST_DECODE;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DECODE: begin
                    r_ins   <= ram_rdata;
                    r_state <= ST_DONE;
                    if (ram_rdata[7]) begin
                        if (!ram_rdata[6]) begin
                            r_spl <= r_pcl; r_sph <= r_pch;
                            r_pcl <= '0; r_pch <= {2'd0, ram_rdata[5:0]};
                        end else if (!ram_rdata[3]) begin
                            r_state <= ST_EXEC;
                        end
                    end else if (ram_rdata[3:0] == DST_NONE) begin
                        case (ram_rdata[6:4])
                            SIG_SCI: r_sis <= {r_sis[6:0], r_sin};
                            SIG_SCO: begin
                                r_sob <= r_sos[7]; r_sov <= 1'b1;
                                r_sos <= {r_sos[6:0], 1'b0};
                            end
                            SIG_CLL: r_clk_line <= 1'b0;
                            SIG_CLH: r_clk_line <= 1'b1;
                            SIG_TRI: r_tri <= 1'b1;
                            SIG_SPI: r_sp <= r_sp + 8'd1;
                            SIG_SPD: r_sp <= r_sp - 8'd1;
                            default: ;
                        endcase
                    end else if (ram_rdata[6:4] == SRC_LIT && ram_rdata[3:0] == DST_M) begin
                        r_pcl <= r_spl; r_pch <= r_sph;       // return
                    end else if (ram_rdata[6:4] == SRC_M && ram_rdata[3:0] == DST_M) begin
                        r_pch <= r_pch + 8'd1;                 // next page
                    end else begin
                        if (ram_rdata[6:4] == SRC_LIT) begin
                            r_pcl <= r_pcl + 8'd1;
                        end
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_DONE;
                    if (r_cmd == CMD_READ) begin
                        r_rd <= ram_rdata;
                    end else if (r_ins[7]) begin
                        if (r_ins[5]) r_acc_b <= ram_rdata;
                        else          r_acc_a <= ram_rdata;
                    end else begin
                        if (src == SRC_ALU) begin
                            r_latch <= n_alu;
                            r_zero  <= n_zero;
                        end
                        case (dst)
                            DST_R:  r_pg_r <= n_src;
                            DST_L:  r_spl <= n_src;
                            DST_H:  r_sph <= n_src;
                            DST_SO: r_sos <= n_src;
                            DST_P: begin
                                r_tri <= 1'b0; r_pov <= 1'b1; r_pod <= n_src;
                            end
                            DST_F: begin
                                r_func <= n_src; r_hold <= 1'b0;
                            end
                            DST_D:  r_dsel <= n_src;
                            DST_G:  r_pg_g <= n_src;
                            DST_J: begin
                                r_pch <= n_src; r_pcl <= '0;
                            end
                            DST_T: if (!n_zero) begin
                                r_pch <= n_src; r_pcl <= '0;
                            end
                            DST_E: if (n_zero) begin
                                r_pch <= n_src; r_pcl <= '0;
                            end
                            DST_C: begin
                                r_spl <= r_pcl; r_sph <= r_pch;
                                r_pcl <= '0; r_pch <= n_src;
                            end
                            DST_A: begin
                                r_acc_a <= n_src; r_lwb <= 1'b0; r_hold <= 1'b1;
                            end
                            DST_B: begin
                                r_acc_b <= n_src; r_lwb <= 1'b1; r_hold <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {2'd0, r_dsel, r_pod, r_pov, r_tri, r_sov, r_sob,
                                     r_clk_line, r_zero, r_pch, r_pcl, r_rd};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    logic unused;
    assign unused = ^{s_axis_tdata[IN_W-1:35]};
endmodule

// File: verif/ebcpu_checker.sv
`timescale 1ns / 1ps
// Checker for the 8-bit CPU step block: watches both streams, predicts each result and compares.
module ebcpu_checker
    import ebcpu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [IN_W-1:0]  i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [OUT_W-1:0] i_m_data,
    output int          o_taken,
    output int          o_pending,
    output int          o_failures,
    output logic [15:0] o_last_pc
);
    // lowest field last, to match the tdata packing
    typedef struct packed {
        logic [7:0]  dsel;
        logic [7:0]  po_data;
        logic        po_valid;
        logic        tri_st;
        logic        so_valid;
        logic        so_bit;
        logic        sclk;
        logic        zf;
        logic [15:0] pc;
        logic [7:0]  rd;
    } t_cpu_view;

    logic [7:0] mem [0:65535];
    logic [7:0] pcl, pch, spl, sph, reg_r, reg_d, reg_g, stk, acc_a, acc_b;
    logic [7:0] alu_fn, alu_q, si_sh, so_sh;
    logic       sel_b, hold, zf, clk_line, tri_st;
    logic       cur_sin;
    logic [7:0] cur_pin;
    logic       so_bit, so_valid, po_valid;
    logic [7:0] po_data;
    t_cpu_view  expected_q [$];

    function automatic logic [7:0] fetch();
        logic [7:0] v;
        v = mem[{pch, pcl}];
        pcl = pcl + 8'd1;
        return v;
    endfunction

    function automatic logic [15:0] m_addr();
        logic [7:0] w;
        w = sel_b ? acc_b : acc_a;
        if (w < GLOBAL_BASE) return {reg_r, w};
        if (w < STACK_BASE) return {reg_g, w};
        return {stk, w};
    endfunction

    function automatic logic [7:0] alu_eval();
        logic [7:0] r;
        logic [8:0] sum;
        if (hold) return alu_q;
        sum = {1'b0, acc_a} + {1'b0, acc_b};
        case (alu_fn[3:0])
            ALU_A:     r = acc_a;
            ALU_B:     r = acc_b;
            ALU_NOTA:  r = ~acc_a;
            ALU_NOTB:  r = ~acc_b;
            ALU_SHLA:  r = acc_a << 1;
            ALU_SHLB:  r = acc_b << 1;
            ALU_SHRA:  r = acc_a >> 1;
            ALU_SHRB:  r = acc_b >> 1;
            ALU_AND:   r = acc_a & acc_b;
            ALU_OR:    r = acc_a | acc_b;
            ALU_XOR:   r = acc_a ^ acc_b;
            ALU_ADD:   r = sum[7:0];
            ALU_CARRY: r = {7'd0, sum[8]};
            ALU_LT:    r = (acc_a < acc_b) ? 8'hFF : 8'h00;
            ALU_EQ:    r = (acc_a == acc_b) ? 8'hFF : 8'h00;
            default:   r = (acc_a > acc_b) ? 8'hFF : 8'h00;
        endcase
        alu_q = r + {alu_fn[7:4], 4'd0};
        zf = (alu_q == 8'd0);
        return alu_q;
    endfunction

    function automatic void call_page(logic [7:0] page);
        spl = pcl;
        sph = pch;
        pcl = 8'd0;
        pch = page;
    endfunction

    function automatic logic [7:0] source(logic [2:0] s);
        case (s)
            SRC_LIT: return fetch();
            SRC_R:   return reg_r;
            SRC_M:   return mem[m_addr()];
            SRC_L:   return spl;
            SRC_H:   return sph;
            SRC_SI:  return si_sh;
            SRC_P:   return cur_pin;
            default: return alu_eval();
        endcase
    endfunction

    function automatic void sink(logic [3:0] d, logic [7:0] v);
        case (d)
            DST_R:  reg_r = v;
            DST_M:  mem[m_addr()] = v;
            DST_L:  spl = v;
            DST_H:  sph = v;
            DST_SO: so_sh = v;
            DST_P:  begin tri_st = 1'b0; po_valid = 1'b1; po_data = v; end
            DST_F:  begin alu_fn = v; hold = 1'b0; end
            DST_D:  reg_d = v;
            DST_G:  reg_g = v;
            DST_J:  begin pch = v; pcl = 8'd0; end
            DST_T:  if (!zf) begin pch = v; pcl = 8'd0; end
            DST_E:  if (zf) begin pch = v; pcl = 8'd0; end
            DST_C:  call_page(v);
            DST_A:  begin acc_a = v; sel_b = 1'b0; hold = 1'b1; end
            DST_B:  begin acc_b = v; sel_b = 1'b1; hold = 1'b1; end
            default: ;
        endcase
    endfunction

    function automatic void run_transfer(logic [6:0] ins);
        logic [3:0] d;
        logic [2:0] s;
        d = ins[3:0];
        s = ins[6:4];
        if (d != DST_NONE) begin
            if (s == SRC_LIT && d == DST_M) begin
                pcl = spl;  // return
                pch = sph;
            end else if (s == SRC_M && d == DST_M) begin
                pch = pch + 8'd1;
            end else begin
                sink(d, source(s));
            end
            return;
        end
        case (s)
            SIG_SCI: si_sh = {si_sh[6:0], cur_sin};
            SIG_SCO: begin so_bit = so_sh[7]; so_valid = 1'b1; so_sh = so_sh << 1; end
            SIG_CLL: clk_line = 1'b0;
            SIG_CLH: clk_line = 1'b1;
            SIG_TRI: tri_st = 1'b1;
            SIG_SPI: stk = stk + 8'd1;
            SIG_SPD: stk = stk - 8'd1;
            default: ;
        endcase
    endfunction

    function automatic void run_getput(logic [5:0] ins);
        logic [15:0] a;
        a = ins[4] ? ({stk, 8'd0} + STACK_BASE + ins[2:0])
                   : ({reg_g, 8'd0} + GLOBAL_BASE + ins[2:0]);
        if (ins[3]) mem[a] = ins[5] ? acc_b : acc_a;
        else if (ins[5]) acc_b = mem[a];
        else acc_a = mem[a];
    endfunction

    function automatic t_cpu_view predict_step(logic [IN_W-1:0] req);
        t_cpu_view  v;
        logic [1:0] cmd;
        logic [7:0] ins;
        cmd = req[1:0];
        cur_sin = req[26];
        cur_pin = req[34:27];
        so_bit = 1'b0;
        so_valid = 1'b0;
        po_valid = 1'b0;
        po_data = 8'd0;
        v.rd = 8'd0;
        if (cmd == CMD_WRITE) begin
            mem[req[17:2]] = req[25:18];
        end else if (cmd == CMD_READ) begin
            v.rd = mem[req[17:2]];
        end else if (cmd == CMD_EXEC) begin
            ins = fetch();
            if (!ins[7]) run_transfer(ins[6:0]);
            else if (ins[6]) run_getput(ins[5:0]);
            else call_page({2'b00, ins[5:0]});
        end
        v.pc = {pch, pcl};
        v.zf = zf;
        v.sclk = clk_line;
        v.so_bit = so_bit;
        v.so_valid = so_valid;
        v.tri_st = tri_st;
        v.po_valid = po_valid;
        v.po_data = po_data;
        v.dsel = reg_d;
        return v;
    endfunction

    function automatic void report(string what, logic [15:0] exp_v, logic [15:0] got_v);
        if (o_failures < 10)
            $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, exp_v, got_v);
        o_failures++;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_cpu_view e, g;
        if (!i_rst_n) begin
            {pcl, pch, spl, sph, reg_r, reg_d, reg_g, stk} = '0;
            {acc_a, acc_b, alu_fn, alu_q, si_sh, so_sh} = '0;
            {sel_b, hold, zf, clk_line} = '0;
            tri_st = 1'b1;
            expected_q.delete();
            o_taken <= 0;
            o_failures = 0;
            o_last_pc <= '0;
        end else begin
            if (i_s_valid && i_s_ready) begin
                expected_q.push_back(predict_step(i_s_data));
                o_taken <= o_taken + 1;
            end
            if (i_m_valid && i_m_ready) begin
                g = i_m_data[45:0];
                o_last_pc <= g.pc;
                if (expected_q.size() == 0) begin
                    report("unexpected result", '0, g.pc);
                end else begin
                    e = expected_q.pop_front();
                    if (e.rd != g.rd) report("read_data", e.rd, g.rd);
                    if (e.pc != g.pc) report("program_counter", e.pc, g.pc);
                    if (e.zf != g.zf) report("zero_flag", e.zf, g.zf);
                    if (e.sclk != g.sclk) report("serial_clock", e.sclk, g.sclk);
                    if (e.so_bit != g.so_bit) report("serial_out_bit", e.so_bit, g.so_bit);
                    if (e.so_valid != g.so_valid)
                        report("serial_out_valid", e.so_valid, g.so_valid);
                    if (e.tri_st != g.tri_st) report("bus_tristate", e.tri_st, g.tri_st);
                    if (e.po_valid != g.po_valid)
                        report("parallel_out_valid", e.po_valid, g.po_valid);
                    if (e.po_data != g.po_data)
                        report("parallel_out_data", e.po_data, g.po_data);
                    if (e.dsel != g.dsel) report("device_select", e.dsel, g.dsel);
                end
            end
        end
    end
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Top of the 8-bit CPU step testbench: clock, reset, request stimulus and verdict.
module tb;
    import ebcpu_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    int          taken, pending, failures;
    logic [15:0] last_pc;
    logic        gaps_on;
    int          stall_cycles;
    int          n_load, n_read, n_exec, n_nop;
    bit          written [65536];

    eight_bit_cpu_instruction_step DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    ebcpu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready), .i_s_data(s_axis_tdata),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready), .i_m_data(m_axis_tdata),
        .o_taken(taken), .o_pending(pending), .o_failures(failures), .o_last_pc(last_pc)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side back-pressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            if (gaps_on) repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("eight_bit_cpu_instruction_step regression: fail");
            $finish;
        end
    end

    task automatic push_req(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wdata);
        int target;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        target = taken + 1;
        s_axis_tdata = '0;
        s_axis_tdata[34:0] = {8'($urandom), 1'($urandom), wdata, addr, cmd};
        s_axis_tvalid = 1'b1;
        do @(negedge i_clk); while (taken != target);
        s_axis_tvalid = 1'b0;
        case (cmd)
            CMD_WRITE: begin
                n_load++;
                written[addr] = 1'b1;
            end
            CMD_READ:  n_read++;
            CMD_EXEC:  n_exec++;
            default:   n_nop++;
        endcase
    endtask

    task automatic define_byte(logic [15:0] addr);
        if (!written[addr]) push_req(CMD_WRITE, addr, 8'($urandom));
    endtask

    // looks at the predicted state so that every byte the request reads has been written
    task automatic cover_reads(logic [1:0] cmd, logic [15:0] addr);
        logic [15:0] pc;
        logic [7:0]  ins;
        if (cmd == CMD_READ) define_byte(addr);
        if (cmd != CMD_EXEC) return;
        pc = {u_checker.pch, u_checker.pcl};
        define_byte(pc);
        ins = u_checker.mem[pc];
        if (!ins[7]) begin
            if (ins[3:0] != DST_NONE && ins[3:0] != DST_M) begin
                if (ins[6:4] == SRC_LIT) define_byte({pc[15:8], pc[7:0] + 8'd1});
                else if (ins[6:4] == SRC_M) define_byte(u_checker.m_addr());
            end
        end else if (ins[6] && !ins[3]) begin
            define_byte(ins[4] ? {u_checker.stk, STACK_BASE | {5'd0, ins[2:0]}}
                               : {u_checker.reg_g, GLOBAL_BASE | {5'd0, ins[2:0]}});
        end
    endtask

    task automatic send_req(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wdata);
        cover_reads(cmd, addr);
        push_req(cmd, addr, wdata);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    // lays code down at the current PC (wrapping within the page), then runs it
    task automatic run_code(logic [7:0] code [$], int steps);
        logic [15:0] base;
        drain();
        base = last_pc;
        foreach (code[k]) send_req(CMD_WRITE, {base[15:8], base[7:0] + 8'(k)}, code[k]);
        repeat (steps) send_req(CMD_EXEC, 16'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] pick_load_target();
        logic [3:0] dsts [6] = '{DST_A, DST_B, DST_F, DST_D, DST_R, DST_G};
        return {4'd0, dsts[$urandom_range(0, 5)]};
    endfunction

    // random, mostly well-formed instruction run; literals follow literal-source transfers
    task automatic random_code(output logic [7:0] code [$], output int steps);
        int n, roll;
        logic [7:0] ins;
        code = {};
        n = $urandom_range(3, 10);
        steps = n;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) ins = pick_load_target();
            else if (roll < 50) ins = {4'h7, 4'(pick_load_target())} | 8'h70;
            else if (roll < 70) ins = 8'($urandom_range(0, 127));
            else if (roll < 85) ins = 8'($urandom_range(192, 255));
            else if (roll < 95) ins = {1'b0, 3'($urandom_range(1, 7)), 4'd0};
            else ins = 8'($urandom);
            code.push_back(ins);
            if (!ins[7] && ins[6:4] == SRC_LIT && ins[3:0] != DST_NONE && ins[3:0] != DST_M)
                code.push_back(($urandom_range(0, 3) == 0)
                               ? (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00)
                               : 8'($urandom));
        end
    endtask

    initial begin
        logic [7:0] code [$];
        int steps;
        gaps_on = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_rst_n = 1'b0;
        n_load = 0; n_read = 0; n_exec = 0; n_nop = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        gaps_on = 1'b1;

        // directed: ALU with extremes, signals, serial, bus, stack, return, page bump, call
        code = '{8'h0E, 8'hFF, 8'h0F, 8'h01, 8'h07, 8'h0B, 8'h78, 8'h07, 8'hFC, 8'h76,
                 8'h10, 8'h05, 8'hA5, 8'h20, 8'h40, 8'h30, 8'h50, 8'h16, 8'h60, 8'h70,
                 8'hC8, 8'hF7, 8'h22, 8'h02, 8'hBF};
        run_code(code, 22);
        send_req(CMD_WRITE, 16'hFFFF, 8'h00);
        send_req(CMD_READ, 16'hFFFF, 8'hFF);
        send_req(CMD_READ, 16'h0000, 8'h00);
        send_req(CMD_NOP, 16'hFFFF, 8'hFF);

        // random: mostly well-formed runs, some raw noise
        for (int it = 0; n_load + n_exec + n_read + n_nop < 1700; it++) begin
            if (n_load + n_exec + n_read + n_nop > 1450) gaps_on = 1'b0;
            if ($urandom_range(0, 9) < 7) begin
                random_code(code, steps);
                run_code(code, steps);
            end else begin
                send_req(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("covered %0d memory loads, %0d reads, %0d instructions, %0d no-ops",
                 n_load, n_read, n_exec, n_nop);
        if (failures == 0)
            $display("eight_bit_cpu_instruction_step regression: pass");
        else
            $display("eight_bit_cpu_instruction_step regression: fail");
        $finish;
    end
endmodule

// File: sim.f
hdl/ebcpu_pkg.sv
hdl/ebcpu_ram.sv
hdl/eight_bit_cpu_instruction_step.sv
verif/ebcpu_checker.sv
verif/tb.sv
